[src/sdiv_pkg.sv]
package sdiv_pkg;

    // accumulator width: holds (p+2)*256*wanted and src - k*(d-1), signed
    localparam int ACC_W = 50;

    localparam logic [7:0] PS_MIN = 8'd2;
    localparam logic [7:0] PS_MAX = 8'd254;
    localparam logic [8:0] PD_MAX = 9'd256;
    localparam logic [8:0] PD_MIN = 9'd2;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 9;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [ACC_W-1:0]   a;
        logic [ACC_W-1:0]   b;
        logic [MUL_A_W-1:0] mul_a;
        logic [MUL_B_W-1:0] mul_b;
    } alu_req_t;

endpackage

[src/sdiv_alu.sv]
module sdiv_alu
    import sdiv_pkg::*;
(
    input  alu_req_t           req,
    output logic [ACC_W-1:0]   sum,
    output logic [MUL_P_W-1:0] prod
);

    // one adder/subtractor, two's complement
    always_comb begin
        unique case (req.op)
            ALU_ADD: sum = req.a + req.b;
            ALU_SUB: sum = req.a - req.b;
            default: sum = req.a + req.b;
        endcase
    end

    // small 33x9 multiplier
    assign prod = MUL_P_W'(req.mul_a) * MUL_P_W'(req.mul_b);

endmodule

[src/spi_clock_divider_search_unit.sv]
// Serial clock two-stage divider search.
//
// Input channel (s_valid/s_ready): source clock rate and wanted serial clock
// rate, both in hertz. Result channel (m_valid/m_ready): the even prescale
// (2..254), the post divider (1..256) and the achieved rate
// source/(prescale*postdiv), rounded down. Invalid requests (zero rate,
// wanted above source, source too fast for any prescale) give all zeros.
//
// One item at a time: s_ready is high only while the sequencer is idle.
// A valid item runs the validity check, P <= 127 prescale trials, the k
// products, D <= 255 post divider trials, the divisor product and the
// division, then returns to idle once its result is loaded. All
// trials and the 32 restoring division steps run on one shared 50-bit
// adder; a small multiplier forms the divider products.
//
// Results sit in an output register. A new item is accepted while a result
// waits; if the receiver stalls, the next result is held in the sequencer
// until the output register frees up.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops
// m_valid.
module spi_clock_divider_search_unit
    import sdiv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_source_hz,
    input  logic [31:0] s_wanted_hz,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_achieved_hz,
    output logic [7:0]  m_prescale,
    output logic [8:0]  m_postdiv
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,      // validity check: src - want
        ST_PS_INIT,  // r = 1024*want - src
        ST_PS_LOOP,  // prescale trials
        ST_WP1,      // want + 1
        ST_KMUL,     // k = (want+1)*ps
        ST_K255,     // 255*k
        ST_T_INIT,   // t = src - 255*k
        ST_PD_LOOP,  // post divider trials
        ST_DMUL,     // divisor = ps*pd
        ST_DIV,      // restoring division, one bit per cycle
        ST_FIN
    } state_t;

    state_t state_reg;

    logic [31:0]      src_reg;
    logic [31:0]      want_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [40:0]      k_reg;
    logic [7:0]       p_reg;
    logic [8:0]       d_reg;
    logic [15:0]      dvsr_reg;
    logic [15:0]      rem_reg;
    logic [31:0]      quo_reg;
    logic [4:0]       cnt_reg;

    logic        m_valid_reg;
    logic [31:0] m_ach_reg;
    logic [7:0]  m_ps_reg;
    logic [8:0]  m_pd_reg;

    alu_req_t             alu_req;
    logic [ACC_W-1:0]     alu_sum;
    logic [MUL_P_W-1:0]   mul_prod;
    logic                 acc_pos;
    logic                 sum_neg;
    logic                 out_load;

    sdiv_alu u_alu (
        .req  (alu_req),
        .sum  (alu_sum),
        .prod (mul_prod)
    );

    assign sum_neg  = alu_sum[ACC_W-1];
    assign acc_pos  = !acc_reg[ACC_W-1] && (acc_reg != '0);
    // result moves into the output register when it is empty or draining
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // operand selection for the shared unit
    always_comb begin
        alu_req.op    = ALU_ADD;
        alu_req.a     = '0;
        alu_req.b     = '0;
        alu_req.mul_a = '0;
        alu_req.mul_b = '0;
        unique case (state_reg)
            ST_CHK: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {{(ACC_W-32){1'b0}}, src_reg};
                alu_req.b  = {{(ACC_W-32){1'b0}}, want_reg};
            end
            ST_PS_INIT: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {{(ACC_W-42){1'b0}}, want_reg, 10'b0};
                alu_req.b  = {{(ACC_W-32){1'b0}}, src_reg};
            end
            ST_PS_LOOP: begin
                alu_req.a = acc_reg;
                alu_req.b = {{(ACC_W-41){1'b0}}, want_reg, 9'b0};
            end
            ST_WP1: begin
                alu_req.a = {{(ACC_W-32){1'b0}}, want_reg};
                alu_req.b = {{(ACC_W-1){1'b0}}, 1'b1};
            end
            ST_KMUL: begin
                alu_req.mul_a = k_reg[MUL_A_W-1:0];
                alu_req.mul_b = {1'b0, p_reg};
            end
            ST_K255: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {{(ACC_W-49){1'b0}}, k_reg, 8'b0};
                alu_req.b  = {{(ACC_W-41){1'b0}}, k_reg};
            end
            ST_T_INIT: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {{(ACC_W-32){1'b0}}, src_reg};
                alu_req.b  = acc_reg;
            end
            ST_PD_LOOP: begin
                alu_req.a = acc_reg;
                alu_req.b = {{(ACC_W-41){1'b0}}, k_reg};
            end
            ST_DMUL: begin
                alu_req.mul_a = {{(MUL_A_W-8){1'b0}}, p_reg};
                alu_req.mul_b = d_reg;
            end
            ST_DIV: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {{(ACC_W-17){1'b0}}, rem_reg, quo_reg[31]};
                alu_req.b  = {{(ACC_W-16){1'b0}}, dvsr_reg};
            end
            default: begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        src_reg   <= s_source_hz;
                        want_reg  <= s_wanted_hz;
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (sum_neg || src_reg == '0 || want_reg == '0) begin
                        quo_reg   <= '0;
                        p_reg     <= '0;
                        d_reg     <= '0;
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_PS_INIT;
                    end
                end
                ST_PS_INIT: begin
                    acc_reg   <= alu_sum;
                    p_reg     <= PS_MIN;
                    state_reg <= ST_PS_LOOP;
                end
                ST_PS_LOOP: begin
                    // acc holds (p+2)*256*want - src
                    if (acc_pos) begin
                        state_reg <= ST_WP1;
                    end else if (p_reg == PS_MAX) begin
                        quo_reg   <= '0;
                        p_reg     <= '0;
                        d_reg     <= '0;
                        state_reg <= ST_FIN;
                    end else begin
                        acc_reg <= alu_sum;
                        p_reg   <= p_reg + 8'd2;
                    end
                end
                ST_WP1: begin
                    k_reg     <= alu_sum[40:0];
                    state_reg <= ST_KMUL;
                end
                ST_KMUL: begin
                    k_reg     <= mul_prod[40:0];
                    state_reg <= ST_K255;
                end
                ST_K255: begin
                    acc_reg   <= alu_sum;
                    state_reg <= ST_T_INIT;
                end
                ST_T_INIT: begin
                    acc_reg   <= alu_sum;
                    d_reg     <= PD_MAX;
                    state_reg <= ST_PD_LOOP;
                end
                ST_PD_LOOP: begin
                    // src/(ps*(d-1)) > want  <=>  src - (want+1)*ps*(d-1) >= 0
                    if (!acc_reg[ACC_W-1]) begin
                        state_reg <= ST_DMUL;
                    end else if (d_reg == PD_MIN) begin
                        d_reg     <= 9'd1;
                        state_reg <= ST_DMUL;
                    end else begin
                        acc_reg <= alu_sum;
                        d_reg   <= d_reg - 9'd1;
                    end
                end
                ST_DMUL: begin
                    dvsr_reg  <= mul_prod[15:0];
                    rem_reg   <= '0;
                    quo_reg   <= src_reg;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (!sum_neg) begin
                        rem_reg <= alu_sum[15:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[14:0], quo_reg[31]};
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_load) begin
                        m_ach_reg   <= quo_reg;
                        m_ps_reg    <= p_reg;
                        m_pd_reg    <= d_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_achieved_hz = m_ach_reg;
    assign m_prescale    = m_ps_reg;
    assign m_postdiv     = m_pd_reg;

`ifndef ASSERT_OFF
    // busy after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // prescale is always even
    a_prescale_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_prescale[0])
        else $error("odd prescale");

    // invalid result is all zero, valid result has a post divider
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_prescale == 8'd0) ==
                     (m_postdiv == 9'd0 && m_achieved_hz == 32'd0)))
        else $error("inconsistent invalid result");
`endif

endmodule

[tb/spi_clock_divider_search_unit_tb.sv]
module spi_clock_divider_search_unit_tb;

    // Search bounds of the divider pair
    localparam int unsigned PRESCALE_MIN       = 2;
    localparam int unsigned PRESCALE_MAX       = 254;
    localparam int unsigned POSTDIV_MAX        = 256;
    localparam int unsigned STEPS_PER_PRESCALE = 256;

    // Wait limits, each with a wide margin over the worst item
    localparam int unsigned DRAIN_CYCLES    = 500;
    localparam int unsigned HOLD_CYCLES     = 2000;
    localparam int unsigned WATCHDOG_LIMIT  = 20000;
    localparam int unsigned RANDOM_PER_PASS = 464;

    // Kinds of random request
    typedef enum int unsigned {
        REQ_WELL_FORMED,
        REQ_ANY,
        REQ_ZERO_SOURCE,
        REQ_ZERO_WANTED,
        REQ_WANTED_ABOVE,
        REQ_TOO_FAST
    } request_kind_t;

    typedef struct packed {
        logic [31:0] achieved_hz;
        logic [7:0]  prescale;
        logic [8:0]  postdiv;
    } divider_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [31:0] s_source_hz   = '0;
    logic [31:0] s_wanted_hz   = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [31:0] m_achieved_hz;
    logic [7:0]  m_prescale;
    logic [8:0]  m_postdiv;

    // Predicted divider settings, oldest first
    divider_result_t divider_results_q[$];
    divider_result_t oldest_setting;

    int unsigned sender_idle_pct   = 7;
    int unsigned receiver_idle_pct = 52;
    int unsigned error_count       = 0;
    int unsigned quiet_cycles      = 0;
    int unsigned hold_left         = 0;
    bit          start_hold        = 1'b0;

    spi_clock_divider_search_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_source_hz   (s_source_hz),
        .s_wanted_hz   (s_wanted_hz),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_achieved_hz (m_achieved_hz),
        .m_prescale    (m_prescale),
        .m_postdiv     (m_postdiv)
    );

    always #1 aclk = ~aclk;

    // Divider search: smallest even prescale that keeps the post divider
    // within 256, then the largest post divider that still leaves one step of
    // headroom above the wanted rate. Invalid requests give all zeros.
    function automatic divider_result_t predict_divider_setting(
        input logic [31:0] src,
        input logic [31:0] want
    );
        divider_result_t res;
        logic [63:0]     ceiling;
        int unsigned     ps;
        int unsigned     pd;
        int unsigned     p;
        int unsigned     d;
        res = '0;
        ps  = 0;
        pd  = 1;
        if (src == 0 || want == 0 || want > src) begin
            return res;
        end
        // exact 64-bit product, no wrap
        for (p = PRESCALE_MIN; p <= PRESCALE_MAX && ps == 0; p += 2) begin
            ceiling = {32'd0, want};
            ceiling = ceiling * (p + 2) * STEPS_PER_PRESCALE;
            if ({32'd0, src} < ceiling) begin
                ps = p;
            end
        end
        if (ps == 0) begin
            return res;
        end
        for (d = POSTDIV_MAX; d > 1 && pd == 1; d--) begin
            if (src / (ps * (d - 1)) > want) begin
                pd = d;
            end
        end
        res.achieved_hz = src / (ps * pd);
        res.prescale    = ps[7:0];
        res.postdiv     = pd[8:0];
        return res;
    endfunction

    // Offer one item, holding it until accepted; the prediction is queued at
    // the accepting edge. s_valid stays high afterwards so back-to-back items
    // need no extra NBA in the same step.
    task automatic send_request(input logic [31:0] src, input logic [31:0] want);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_source_hz <= src;
        s_wanted_hz <= want;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        divider_results_q.push_back(predict_divider_setting(src, want));
    endtask

    // Drop valid for one cycle so a lingering item is never taken twice
    task automatic end_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly valid pairs spread over every prescale, rest is random or invalid noise
    task automatic make_random_request(output logic [31:0] src, output logic [31:0] want);
        request_kind_t kind;
        int unsigned   roll;
        int unsigned   wbits;
        logic [63:0]   top;
        logic [63:0]   span;
        logic [63:0]   offset;
        roll = $urandom_range(0, 99);
        if (roll < 70)      kind = REQ_WELL_FORMED;
        else if (roll < 80) kind = REQ_ANY;
        else if (roll < 85) kind = REQ_ZERO_SOURCE;
        else if (roll < 90) kind = REQ_ZERO_WANTED;
        else if (roll < 95) kind = REQ_WANTED_ABOVE;
        else                kind = REQ_TOO_FAST;
        case (kind)
            REQ_ANY: begin
                src  = $urandom;
                want = $urandom;
            end
            REQ_ZERO_SOURCE: begin
                src  = '0;
                want = $urandom;
            end
            REQ_ZERO_WANTED: begin
                src  = $urandom;
                want = '0;
            end
            REQ_WANTED_ABOVE: begin
                src  = $urandom_range(0, 32'hFFFF_FFFE);
                want = src + 1 + $urandom_range(0, 32'hFFFF_FFFE - src);
            end
            REQ_TOO_FAST: begin
                want = $urandom_range(1, 65535);
                src  = want * 65536;
                src  = src + $urandom_range(0, 32'hFFFF_FFFF - src);
            end
            default: begin
                // wanted rate of random magnitude, source between wanted and
                // the fastest rate a prescale of 254 still covers
                wbits = $urandom_range(1, 32);
                want  = $urandom >> (32 - wbits);
                if (want == 0) begin
                    want = 1;
                end
                top = {32'd0, want} * 65536 - 1;
                if (top > 64'hFFFF_FFFF) begin
                    top = 64'hFFFF_FFFF;
                end
                span   = top - want;
                offset = {$urandom, $urandom} >> $urandom_range(0, 63);
                if (offset > span) begin
                    offset = offset % (span + 1);
                end
                src = want + offset[31:0];
            end
        endcase
    endtask

    // Zero rates, wanted above source, and sources too fast for any prescale
    task automatic test_invalid_requests();
        send_request(32'd0,          32'd0);
        send_request(32'd0,          32'd5);
        send_request(32'd0,          32'hFFFF_FFFF);
        send_request(32'd100,        32'd0);
        send_request(32'hFFFF_FFFF,  32'd0);
        send_request(32'd1000,       32'd1001);
        send_request(32'hFFFF_FFFE,  32'hFFFF_FFFF);
        send_request(32'd65_536_000, 32'd1000);     // exactly 65536 x wanted
        send_request(32'hFFFF_FFFF,  32'd1);
        send_request(32'hFFFF_0000,  32'h0000_FFFF);
        end_burst();
    endtask

    // Field extremes and the edges of each search stage
    task automatic test_range_limits();
        send_request(32'd1,          32'd1);        // valid, achieved rounds to 0
        send_request(32'd1000,       32'd1000);     // equal rates, post divider 1
        send_request(32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_request(32'd1023,       32'd1);        // prescale 2, post divider 256
        send_request(32'd1024,       32'd1);        // first step to prescale 4
        send_request(32'd65_535_999, 32'd1000);     // prescale 254
        send_request(32'hFFFE_FFFF,  32'h0000_FFFF);
        send_request(32'hFFFF_FFFF,  32'd10000);
        send_request(32'hAAAA_AAAA,  32'h5555_5555);
        send_request(32'h5555_5555,  32'h0055_5555);
        end_burst();
    endtask

    task automatic test_random_traffic(input int unsigned count);
        logic [31:0] src;
        logic [31:0] want;
        repeat (count) begin
            make_random_request(src, want);
            send_request(src, want);
        end
        end_burst();
    endtask

    // Long receiver stall: output register and sequencer both fill, so the
    // input must stall while items keep being offered
    task automatic test_output_stall();
        logic [31:0] src;
        logic [31:0] want;
        start_hold = 1'b1;
        repeat (8) begin
            make_random_request(src, want);
            send_request(src, want);
        end
        end_burst();
    endtask

    // Receiver: random ready, or a counted hold-off on request
    always @(posedge aclk) begin
        if (start_hold) begin
            hold_left  = HOLD_CYCLES;
            start_hold = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Result checker: every accepted result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (divider_results_q.size() == 0) begin
                $display("%0t: unexpected result achieved_hz %0d prescale %0d postdiv %0d",
                         $time, m_achieved_hz, m_prescale, m_postdiv);
                error_count++;
            end else begin
                oldest_setting = divider_results_q.pop_front();
                if (m_achieved_hz !== oldest_setting.achieved_hz) begin
                    $display("%0t: achieved_hz expected %0d actual %0d",
                             $time, oldest_setting.achieved_hz, m_achieved_hz);
                    error_count++;
                end
                if (m_prescale !== oldest_setting.prescale) begin
                    $display("%0t: prescale expected %0d actual %0d",
                             $time, oldest_setting.prescale, m_prescale);
                    error_count++;
                end
                if (m_postdiv !== oldest_setting.postdiv) begin
                    $display("%0t: postdiv expected %0d actual %0d",
                             $time, oldest_setting.postdiv, m_postdiv);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no item moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding",
                     $time, divider_results_q.size());
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender rarely idles, receiver often stalls
        sender_idle_pct   = 7;
        receiver_idle_pct = 52;
        test_invalid_requests();
        test_range_limits();
        test_random_traffic(RANDOM_PER_PASS);

        // roles swapped
        sender_idle_pct   = 52;
        receiver_idle_pct = 7;
        test_random_traffic(RANDOM_PER_PASS);

        // full rate on both sides
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_traffic(RANDOM_PER_PASS);
        test_output_stall();

        while (divider_results_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[spi_clock_divider_search_unit.f]
src/sdiv_pkg.sv
src/sdiv_alu.sv
src/spi_clock_divider_search_unit.sv
tb/spi_clock_divider_search_unit_tb.sv
